FILE: rtl/core/pts_pkg.sv
package pts_pkg;

    localparam int SLOTS           = 16;
    localparam int QUEUES          = 8;
    localparam int PRIORITY_LEVELS = 32;
    localparam int SLOT_W          = $clog2(SLOTS);
    localparam int QUEUE_W         = 3;
    localparam int PRIO_W          = 5;
    localparam logic [PRIO_W-1:0] MAIN_PRIO = 5'd16;

    typedef enum logic [1:0] {
        ST_READY    = 2'd0,
        ST_RUNNING  = 2'd1,
        ST_WAITING  = 2'd2,
        ST_FINISHED = 2'd3
    } t_slot_state;

    typedef enum logic [3:0] {
        OP_CREATE  = 4'd0,
        OP_RESUME  = 4'd1,
        OP_SUSPEND = 4'd2,
        OP_CANCEL  = 4'd3,
        OP_DISABLE = 4'd4,
        OP_ENABLE  = 4'd5,
        OP_SLEEP   = 4'd6,
        OP_WAKEUP  = 4'd7,
        OP_COUNT   = 4'd8,
        OP_EXIT    = 4'd9
    } t_opcode;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NO_FREE   = 2'd1;
    localparam logic [1:0] STS_NO_RUN    = 2'd2;
    localparam logic [1:0] STS_NO_SLOT   = 2'd3;

endpackage

FILE: rtl/core/priority_thread_scheduler.sv
// Channel | Direction | Beat fields                                  | Handshake
// input   | in        | opcode, slot, priority_req, queue_id        | i_valid / o_stall
// result  | out       | status, value, running_slot, switched       | o_valid / i_stall
//
// A single compare unit looks at one slot per cycle. An operation passes S_OP
// and S_DONE; create, wakeup and count also walk the table in S_SCAN, and a
// reschedule walks it once in S_SCHED, then S_RESCHED, unless scheduling is
// disabled. Reset is synchronous and restores slot 0 as the running main task.
// o_stall stays high until the result beat has been taken.
module priority_thread_scheduler
    import pts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [3:0]        i_opcode,
    input  logic [3:0]        i_slot,
    input  logic [4:0]        i_priority_req,
    input  logic [2:0]        i_queue_id,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic [7:0]        o_value,
    output logic [3:0]        o_running_slot,
    output logic              o_switched
);

    typedef enum logic [2:0] {
        S_IDLE, S_OP, S_SCAN, S_SCHED, S_RESCHED, S_DONE
    } t_state;

    t_state                r_state;
    logic [SLOTS-1:0]      r_present, r_member;
    t_slot_state           r_stat  [SLOTS];
    logic [7:0]            r_susp  [SLOTS];
    logic [PRIO_W-1:0]     r_prio  [SLOTS];
    logic [QUEUE_W-1:0]    r_wq    [SLOTS];
    logic [SLOT_W-1:0]     r_cur, r_before, r_best;
    logic [7:0]            r_dis;
    logic                  r_found;
    logic [SLOT_W-1:0]     r_idx;
    logic [3:0]            r_op;
    logic [SLOT_W-1:0]     r_slot;
    logic [PRIO_W-1:0]     r_preq;
    logic [QUEUE_W-1:0]    r_q;
    logic [1:0]            r_status;
    logic [7:0]            r_value;
    logic                  r_ovalid;

    logic [SLOT_W-1:0]     w_i;
    logic                  w_run_ok, w_better, w_valid_slot;

    assign o_stall        = (r_state != S_IDLE) || r_ovalid;
    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_value        = r_value;
    assign o_running_slot = r_cur;
    assign o_switched     = (r_cur != r_before);

    // Shared compare unit on the slot under the walk pointer
    assign w_i      = r_idx;
    assign w_run_ok = r_present[w_i] && (r_susp[w_i] == 8'd0) &&
                      (r_stat[w_i] == ST_READY || r_stat[w_i] == ST_RUNNING);
    assign w_better = w_run_ok && (!r_found || r_prio[w_i] < r_prio[r_best]);
    assign w_valid_slot = r_present[r_slot];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_present <= SLOTS'(1);
            r_member  <= '0;
            for (int k = 0; k < SLOTS; k++) begin
                r_stat[k] <= (k == 0) ? ST_RUNNING : ST_READY;
                r_susp[k] <= 8'd0;
                r_prio[k] <= (k == 0) ? MAIN_PRIO : '0;
                r_wq[k]   <= '0;
            end
            r_cur    <= '0;
            r_before <= '0;
            r_dis    <= 8'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    // Take a beat once the previous result has gone
                    if (i_valid && !r_ovalid) begin
                        r_op     <= i_opcode;
                        r_slot   <= i_slot;
                        r_preq   <= i_priority_req;
                        r_q      <= i_queue_id;
                        r_before <= r_cur;
                        r_status <= STS_OK;
                        r_value  <= 8'd0;
                        r_state  <= S_OP;
                    end
                end
                S_OP: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    r_best  <= '0;
                    r_state <= S_DONE;
                    unique case (r_op)
                        OP_CREATE: begin
                            r_idx    <= SLOT_W'(1);
                            r_status <= STS_NO_FREE;
                            r_state  <= S_SCAN;
                        end
                        OP_RESUME, OP_SUSPEND: begin
                            if (!w_valid_slot) r_status <= STS_NO_SLOT;
                            else begin
                                r_value <= r_susp[r_slot];
                                if (r_op == OP_RESUME && r_susp[r_slot] != 8'd0)
                                    r_susp[r_slot] <= r_susp[r_slot] - 8'd1;
                                if (r_op == OP_SUSPEND && r_susp[r_slot] != 8'hFF)
                                    r_susp[r_slot] <= r_susp[r_slot] + 8'd1;
                                r_state <= S_SCHED;
                            end
                        end
                        OP_CANCEL: begin
                            if (!w_valid_slot) r_status <= STS_NO_SLOT;
                            else begin
                                r_stat[r_slot]   <= ST_FINISHED;
                                r_member[r_slot] <= 1'b0;
                                if (r_slot == r_cur) r_state <= S_SCHED;
                            end
                        end
                        OP_DISABLE: begin
                            r_value <= r_dis;
                            if (r_dis != 8'hFF) r_dis <= r_dis + 8'd1;
                        end
                        OP_ENABLE: begin
                            r_value <= r_dis;
                            if (r_dis != 8'd0) r_dis <= r_dis - 8'd1;
                        end
                        OP_SLEEP: begin
                            r_stat[r_cur]   <= ST_WAITING;
                            r_member[r_cur] <= 1'b1;
                            r_wq[r_cur]     <= r_q;
                            r_state         <= S_SCHED;
                        end
                        OP_WAKEUP, OP_COUNT: r_state <= S_SCAN;
                        OP_EXIT: begin
                            r_stat[r_cur]   <= ST_FINISHED;
                            r_member[r_cur] <= 1'b0;
                            r_state         <= S_SCHED;
                        end
                        default: ;
                    endcase
                end
                S_SCAN: begin
                    // Walk one slot a cycle for create, wakeup and count
                    if (r_op == OP_CREATE) begin
                        if (!r_present[w_i] || r_stat[w_i] == ST_FINISHED) begin
                            r_present[w_i] <= 1'b1;
                            r_stat[w_i]    <= ST_READY;
                            r_susp[w_i]    <= 8'd1;
                            r_prio[w_i]    <= r_preq;
                            r_member[w_i]  <= 1'b0;
                            r_wq[w_i]      <= '0;
                            r_status       <= STS_OK;
                            r_value        <= 8'(w_i);
                            r_state        <= S_DONE;
                        end
                    end else if (r_op == OP_WAKEUP) begin
                        if (r_member[w_i] && r_wq[w_i] == r_q) begin
                            r_stat[w_i]   <= ST_READY;
                            r_member[w_i] <= 1'b0;
                        end
                    end else if (r_present[w_i] && r_stat[w_i] != ST_FINISHED
                                 && r_value != 8'hFF) begin
                        r_value <= r_value + 8'd1;
                    end
                    if (r_idx == SLOT_W'(SLOTS - 1)) r_state <= S_DONE;
                    r_idx <= r_idx + SLOT_W'(1);
                end
                S_SCHED: begin
                    // Find the most urgent runnable slot, unless scheduling is disabled
                    if (r_dis != 8'd0) r_state <= S_DONE;
                    else begin
                        if (w_better) begin
                            r_best  <= w_i;
                            r_found <= 1'b1;
                        end
                        if (r_idx == SLOT_W'(SLOTS - 1)) r_state <= S_RESCHED;
                        r_idx <= r_idx + SLOT_W'(1);
                    end
                end
                S_RESCHED: begin
                    if (!r_found) begin
                        r_status <= STS_NO_RUN;
                        if (r_op == OP_RESUME || r_op == OP_SUSPEND) r_value <= 8'd0;
                    end else if (r_best != r_cur) begin
                        if (r_stat[r_cur] == ST_RUNNING) r_stat[r_cur] <= ST_READY;
                        r_stat[r_best] <= ST_RUNNING;
                        r_cur          <= r_best;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (r_status == STS_NO_FREE || r_status == STS_NO_SLOT)
                        r_value <= 8'd0;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
